// ===== design/cbpg_pkg.sv =====
package cbpg_pkg;

    // curve parameter t in Q1.16, one at the top end
    localparam int T_W = 17;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    // step count
    localparam int N_W = 6;
    localparam logic [N_W-1:0] MAX_STEPS = 6'd63;

    // divider for the per-step increment of t
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] DIV_STEPS = 5'd17;

    // Bernstein weights sum to 2^48, split in a high and a low part
    localparam int WGT_W     = 49;
    localparam int W_SPLIT   = 24;
    localparam int ROUND_POS = 47;
    localparam int LANES     = 4;

    // issue-to-result pipeline, not counting the output register
    localparam int PIPE_LEN = 7;

    // controller to datapath
    typedef struct packed {
        logic           load;
        logic [N_W-1:0] steps;
        logic           issue;
        logic           last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic pipe_empty;
    } t_dp_stat;

endpackage

// ===== design/cubic_bezier_point_generator_unit.sv =====
// Cubic Bezier point generator.
// Command channel: a beat is taken on a rising edge with start high and busy low; it
// carries the four control points (signed Q15.8) and the step count N (saturated to 63).
// Result channel: N+1 points, each on o_point_x/o_point_y for one cycle with
// o_point_valid high; o_last_point marks the final one. The receiver cannot stall, so
// points leave one per cycle, back to back, and must be taken as they come.
// Flow: for N > 0 a divider first forms the step of t, then one point is
// issued per cycle into an 8-stage multiply/accumulate pipeline. The points leave in
// consecutive cycles, and busy falls in the cycle after the last point; only then can
// the next command be taken. For N = 0 no division is run and only the first control
// point is produced.
// One command is worked on at a time; the divider and the issue sequence set the rate.
// Reset (synchronous, active low) drops busy and clears any points in flight.
module cubic_bezier_point_generator_unit
    import cbpg_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_handle1_x,
    input  logic signed [COORD_WIDTH-1:0] i_handle1_y,
    input  logic signed [COORD_WIDTH-1:0] i_handle2_x,
    input  logic signed [COORD_WIDTH-1:0] i_handle2_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic [N_W-1:0]                i_step_count,
    output logic                          o_point_valid,
    output logic signed [COORD_WIDTH-1:0] o_point_x,
    output logic signed [COORD_WIDTH-1:0] o_point_y,
    output logic                          o_last_point
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing
    cbpg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_step_count (i_step_count),
        .i_stat       (stat),
        .o_busy       (busy),
        .o_cmd        (cmd)
    );

    // arithmetic
    cbpg_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_pt_x        ({i_end_x, i_handle2_x, i_handle1_x, i_start_x}),
        .i_pt_y        ({i_end_y, i_handle2_y, i_handle1_y, i_start_y}),
        .o_point_valid (o_point_valid),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_last_point  (o_last_point)
    );

endmodule

// ===== design/cbpg_divider.sv =====
module cbpg_divider
    import cbpg_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_divisor,
    output logic           o_done,
    output logic [T_W-1:0] o_quotient,
    output logic [N_W-1:0] o_remainder
);

    logic           r_busy, n_busy;
    logic [CNT_W-1:0] r_count, n_count;
    logic [T_W-1:0] r_quo, n_quo;
    logic [N_W-1:0] r_rem, n_rem;
    logic [N_W-1:0] r_div, n_div;
    logic [N_W:0]   shifted;
    logic           take;

    // restoring division of 2^16 by N, one quotient bit a cycle
    always_comb begin
        n_busy  = r_busy;
        n_count = r_count;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        shifted = {r_rem, r_quo[T_W-1]};
        take    = (shifted >= {1'b0, r_div});
        if (i_start) begin
            n_busy  = 1'b1;
            n_count = DIV_STEPS;
            n_quo   = T_ONE;
            n_rem   = '0;
            n_div   = i_divisor;
        end else if (r_busy) begin
            n_quo   = {r_quo[T_W-2:0], take};
            n_rem   = take ? N_W'(shifted - {1'b0, r_div}) : shifted[N_W-1:0];
            n_count = r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done      = !r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== design/cbpg_datapath.sv =====
module cbpg_datapath
    import cbpg_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_dp_cmd                           i_cmd,
    output t_dp_stat                          o_stat,
    input  logic [LANES-1:0][COORD_WIDTH-1:0] i_pt_x,
    input  logic [LANES-1:0][COORD_WIDTH-1:0] i_pt_y,
    output logic                              o_point_valid,
    output logic signed [COORD_WIDTH-1:0]     o_point_x,
    output logic signed [COORD_WIDTH-1:0]     o_point_y,
    output logic                              o_last_point
);

    localparam int CW    = COORD_WIDTH;
    localparam int SQ_W  = 2 * T_W;
    localparam int CU_W  = SQ_W + T_W;
    localparam int WH_W  = WGT_W - W_SPLIT;
    localparam int PH_W  = WH_W + 1 + CW;
    localparam int PL_W  = W_SPLIT + 1 + CW;
    localparam int PH1_W = PH_W + 1;
    localparam int PL1_W = PL_W + 1;
    localparam int HI_W  = PH_W + 2;
    localparam int LO_W  = ((PL_W + 2 > ROUND_POS + 2) ? PL_W + 2 : ROUND_POS + 2) + 1;
    localparam int Q_W   = LO_W - W_SPLIT;
    localparam int S_W   = ((HI_W > Q_W) ? HI_W : Q_W) + 1;
    localparam int TOP_W = S_W - W_SPLIT;
    localparam logic [LO_W-1:0] ROUND_HALF = LO_W'(49'h0_8000_0000_0000);

    // held control points and step count
    logic signed [CW-1:0] r_px [LANES];
    logic signed [CW-1:0] r_py [LANES];
    logic [N_W-1:0]       r_steps;

    // t accumulator: t = q0*i + carries from the remainder
    logic [T_W-1:0] r_t, n_t;
    logic [N_W-1:0] r_acc_rem, n_acc_rem;
    logic [N_W:0]   rem_sum;
    logic           rem_wrap;

    logic           div_start, div_done;
    logic [T_W-1:0] step_quo;
    logic [N_W-1:0] step_rem;

    // pipeline control
    logic [PIPE_LEN-1:0] r_vld, r_lst;
    logic                r_out_valid, r_last_point;

    // pipeline payload
    logic [T_W-1:0]  r1_t, r1_mt;
    logic [SQ_W-1:0] r2_mt2, r2_t2;
    logic [T_W-1:0]  r2_t, r2_mt;
    logic [CU_W-1:0] r3_w0, r3_a, r3_b, r3_w3;
    logic [WGT_W-1:0] r4_w [LANES];
    logic signed [PH_W-1:0]  r5_hx [LANES];
    logic signed [PH_W-1:0]  r5_hy [LANES];
    logic signed [PL_W-1:0]  r5_lx [LANES];
    logic signed [PL_W-1:0]  r5_ly [LANES];
    logic signed [PH1_W-1:0] r6_hx [2];
    logic signed [PH1_W-1:0] r6_hy [2];
    logic signed [PL1_W-1:0] r6_lx [2];
    logic signed [PL1_W-1:0] r6_ly [2];
    logic signed [HI_W-1:0]  r7_hx, r7_hy;
    logic signed [LO_W-1:0]  r7_lx, r7_ly;
    logic signed [CW-1:0]    r_point_x, r_point_y;

    // combine high and low sums, drop 48 fraction bits, saturate
    function automatic logic signed [CW-1:0] finish_coord(
        input logic signed [HI_W-1:0] hi,
        input logic signed [LO_W-1:0] lo
    );
        logic signed [Q_W-1:0]   q;
        logic signed [S_W-1:0]   sum;
        logic signed [TOP_W-1:0] top;
        logic [TOP_W-CW-1:0]     upper;
        logic signed [CW-1:0]    res;
        q     = $signed(lo[LO_W-1:W_SPLIT]);
        sum   = S_W'(hi) + S_W'(q);
        top   = $signed(sum[S_W-1:W_SPLIT]);
        upper = top[TOP_W-2:CW-1];
        if (!top[TOP_W-1] && (|upper)) begin
            res = $signed({1'b0, {(CW-1){1'b1}}});
        end else if (top[TOP_W-1] && !(&upper)) begin
            res = $signed({1'b1, {(CW-1){1'b0}}});
        end else begin
            res = top[CW-1:0];
        end
        return res;
    endfunction

    // increment of t per step, 2^16 / N
    assign div_start = i_cmd.load && (i_cmd.steps != '0);

    cbpg_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_divisor   (i_cmd.steps),
        .o_done      (div_done),
        .o_quotient  (step_quo),
        .o_remainder (step_rem)
    );

    // capture the command beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < LANES; k++) begin
                r_px[k] <= $signed(i_pt_x[k]);
                r_py[k] <= $signed(i_pt_y[k]);
            end
            r_steps <= i_cmd.steps;
        end
    end

    // next t
    always_comb begin
        rem_sum   = {1'b0, r_acc_rem} + {1'b0, step_rem};
        rem_wrap  = (rem_sum >= {1'b0, r_steps});
        n_acc_rem = rem_wrap ? N_W'(rem_sum - {1'b0, r_steps}) : rem_sum[N_W-1:0];
        n_t       = r_t + step_quo + T_W'(rem_wrap);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t       <= '0;
            r_acc_rem <= '0;
        end else if (i_cmd.issue) begin
            r_t       <= n_t;
            r_acc_rem <= n_acc_rem;
        end
    end

    // valid travels with each point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_vld       <= {r_vld[PIPE_LEN-2:0], i_cmd.issue};
            r_out_valid <= r_vld[PIPE_LEN-1];
        end
    end

    // stages: t and 1-t, squares, cubes, weights, products, two adder levels, output
    always_ff @(posedge i_clk) begin
        r_lst  <= {r_lst[PIPE_LEN-2:0], i_cmd.last};

        r1_t   <= r_t;
        r1_mt  <= T_ONE - r_t;

        r2_mt2 <= r1_mt * r1_mt;
        r2_t2  <= r1_t * r1_t;
        r2_t   <= r1_t;
        r2_mt  <= r1_mt;

        r3_w0  <= r2_mt2 * r2_mt;
        r3_a   <= r2_mt2 * r2_t;
        r3_b   <= r2_t2 * r2_mt;
        r3_w3  <= r2_t2 * r2_t;

        r4_w[0] <= WGT_W'(r3_w0);
        r4_w[1] <= WGT_W'(r3_a + (r3_a << 1));
        r4_w[2] <= WGT_W'(r3_b + (r3_b << 1));
        r4_w[3] <= WGT_W'(r3_w3);

        for (int k = 0; k < LANES; k++) begin
            r5_hx[k] <= $signed({1'b0, r4_w[k][WGT_W-1:W_SPLIT]}) * r_px[k];
            r5_hy[k] <= $signed({1'b0, r4_w[k][WGT_W-1:W_SPLIT]}) * r_py[k];
            r5_lx[k] <= $signed({1'b0, r4_w[k][W_SPLIT-1:0]}) * r_px[k];
            r5_ly[k] <= $signed({1'b0, r4_w[k][W_SPLIT-1:0]}) * r_py[k];
        end

        for (int j = 0; j < 2; j++) begin
            r6_hx[j] <= PH1_W'(r5_hx[2*j]) + PH1_W'(r5_hx[2*j+1]);
            r6_hy[j] <= PH1_W'(r5_hy[2*j]) + PH1_W'(r5_hy[2*j+1]);
            r6_lx[j] <= PL1_W'(r5_lx[2*j]) + PL1_W'(r5_lx[2*j+1]);
            r6_ly[j] <= PL1_W'(r5_ly[2*j]) + PL1_W'(r5_ly[2*j+1]);
        end

        r7_hx <= HI_W'(r6_hx[0]) + HI_W'(r6_hx[1]);
        r7_hy <= HI_W'(r6_hy[0]) + HI_W'(r6_hy[1]);
        r7_lx <= LO_W'(r6_lx[0]) + LO_W'(r6_lx[1]) + $signed(ROUND_HALF);
        r7_ly <= LO_W'(r6_ly[0]) + LO_W'(r6_ly[1]) + $signed(ROUND_HALF);

        r_point_x    <= finish_coord(r7_hx, r7_lx);
        r_point_y    <= finish_coord(r7_hy, r7_ly);
        r_last_point <= r_lst[PIPE_LEN-1];
    end

    assign o_stat.div_done   = div_done;
    assign o_stat.pipe_empty = ~|r_vld;

    assign o_point_valid = r_out_valid;
    assign o_point_x     = r_point_x;
    assign o_point_y     = r_point_y;
    assign o_last_point  = r_last_point;

endmodule

// ===== design/cbpg_ctrl.sv =====
module cbpg_ctrl
    import cbpg_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_step_count,
    input  t_dp_stat       i_stat,
    output logic           o_busy,
    output t_dp_cmd        o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN,
        ST_DRAIN
    } t_state;

    t_state         r_state, n_state;
    logic           r_busy, n_busy;
    logic [N_W-1:0] r_steps, n_steps;
    logic [N_W-1:0] r_idx, n_idx;
    logic [N_W-1:0] steps_sat;
    logic           at_last;

    assign steps_sat = (i_step_count > MAX_STEPS) ? MAX_STEPS : i_step_count;
    assign at_last   = (r_idx == r_steps);

    // next state
    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_steps = r_steps;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_busy  = 1'b1;
                    n_steps = steps_sat;
                    n_idx   = '0;
                    n_state = (steps_sat == '0) ? ST_RUN : ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (at_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + N_W'(1);
                end
            end
            ST_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = ST_IDLE;
                    n_busy  = 1'b0;
                    n_idx   = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
            r_steps <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_steps <= n_steps;
            r_idx   <= n_idx;
        end
    end

    // commands
    assign o_cmd.load  = (r_state == ST_IDLE) && i_start;
    assign o_cmd.steps = steps_sat;
    assign o_cmd.issue = (r_state == ST_RUN);
    assign o_cmd.last  = at_last;
    assign o_busy      = r_busy;

endmodule

// ===== design/cbpg_checker.sv =====
module cbpg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_point_valid,
    input logic o_last_point
);

    // points only appear while a command is in hand
    a_point_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid |-> busy)
        else $error("point strobe while not busy");

    // points of one curve come in consecutive cycles
    a_burst_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid && !o_last_point |=> o_point_valid)
        else $error("gap inside a point burst");

    // the last point releases the block
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point_valid && o_last_point |=> !busy)
        else $error("busy held after last point");

    // busy only falls after a last point
    a_fall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_point_valid && o_last_point))
        else $error("busy fell without a last point");

    // no point straight after a command beat
    a_no_early_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_point_valid)
        else $error("point right after command beat");

endmodule

bind cubic_bezier_point_generator_unit cbpg_checker u_checker (.*);

// ===== tb/cubic_bezier_point_generator_unit_test.sv =====
`timescale 1ns / 100ps

module cubic_bezier_point_generator_unit_test
    import cbpg_pkg::*;
();

    localparam int COORD_W      = 24;
    localparam int N_RANDOM     = 310;
    localparam int QUIET_ITEMS  = 80;
    localparam int IDLE_PCT     = 34;
    localparam int END_SETTLE   = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // control point slots in a command beat
    localparam int P0_X = 0;
    localparam int P0_Y = 1;
    localparam int P1_X = 2;
    localparam int P1_Y = 3;
    localparam int P2_X = 4;
    localparam int P2_Y = 5;
    localparam int P3_X = 6;
    localparam int P3_Y = 7;

    localparam logic [COORD_W-1:0] C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] C_ZERO = '0;
    localparam logic [COORD_W-1:0] C_NEG1 = '1;

    localparam logic signed [79:0] SUM_HI     = (80'sd1 <<< (COORD_W - 1)) - 80'sd1;
    localparam logic signed [79:0] SUM_LO     = -SUM_HI - 80'sd1;
    localparam logic signed [79:0] ROUND_HALF = 80'sd1 <<< 47;

    // one command beat; known marks a row whose points are typed in
    typedef struct packed {
        logic [7:0][COORD_W-1:0] pts;
        logic [N_W-1:0]          steps;
        logic                    known;
        logic [COORD_W-1:0]      kx;
        logic [COORD_W-1:0]      ky;
    } t_curve_cmd;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_curve_point;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    logic                          o_point_valid;
    logic signed [COORD_W-1:0]     o_point_x;
    logic signed [COORD_W-1:0]     o_point_y;
    logic                          o_last_point;

    t_curve_cmd   cur_cmd = '0;
    t_curve_cmd   directed_rows [$];
    t_curve_point curve_points_q [$];
    int           mismatches  = 0;
    int           cycle_count = 0;

    cubic_bezier_point_generator_unit #(
        .COORD_WIDTH (COORD_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_start_x     (cur_cmd.pts[P0_X]),
        .i_start_y     (cur_cmd.pts[P0_Y]),
        .i_handle1_x   (cur_cmd.pts[P1_X]),
        .i_handle1_y   (cur_cmd.pts[P1_Y]),
        .i_handle2_x   (cur_cmd.pts[P2_X]),
        .i_handle2_y   (cur_cmd.pts[P2_Y]),
        .i_end_x       (cur_cmd.pts[P3_X]),
        .i_end_y       (cur_cmd.pts[P3_Y]),
        .i_step_count  (cur_cmd.steps),
        .o_point_valid (o_point_valid),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_last_point  (o_last_point)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // exact Bernstein blend of one axis, rounded half up, then clamped
    function automatic logic [COORD_W-1:0] bernstein_blend(
        input longint unsigned w0, input longint unsigned w1,
        input longint unsigned w2, input longint unsigned w3,
        input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c, input logic signed [COORD_W-1:0] d);
        logic signed [79:0] pa, pb, pc, pd, acc;
        pa  = a;
        pb  = b;
        pc  = c;
        pd  = d;
        acc = $signed({16'd0, w0}) * pa + $signed({16'd0, w1}) * pb
            + $signed({16'd0, w2}) * pc + $signed({16'd0, w3}) * pd + ROUND_HALF;
        acc = acc >>> 48;
        if (acc > SUM_HI) acc = SUM_HI;
        if (acc < SUM_LO) acc = SUM_LO;
        return acc[COORD_W-1:0];
    endfunction

    // queue every point that one accepted command beat should produce
    function automatic void predict_curve_points(input t_curve_cmd c);
        longint unsigned t, mt, w0, w1, w2, w3;
        int n;
        t_curve_point pt;
        n = c.steps;
        for (int i = 0; i <= n; i++) begin
            t  = (n == 0) ? 0 : (longint'(i) << 16) / n;
            mt = 65536 - t;
            w0 = mt * mt * mt;
            w1 = 3 * mt * mt * t;
            w2 = 3 * mt * t * t;
            w3 = t * t * t;
            if (c.known) begin
                pt.x = c.kx;
                pt.y = c.ky;
            end else begin
                pt.x = bernstein_blend(w0, w1, w2, w3, c.pts[P0_X], c.pts[P1_X],
                                       c.pts[P2_X], c.pts[P3_X]);
                pt.y = bernstein_blend(w0, w1, w2, w3, c.pts[P0_Y], c.pts[P1_Y],
                                       c.pts[P2_Y], c.pts[P3_Y]);
            end
            pt.last = (i == n);
            curve_points_q.insert(curve_points_q.size(), pt);
        end
    endfunction

    // append one row to the stimulus table
    function automatic void add_row(input t_curve_cmd c);
        directed_rows.insert(directed_rows.size(), c);
    endfunction

    task automatic report_mismatch(input string what, input logic [COORD_W-1:0] got,
                                   input logic [COORD_W-1:0] want);
        mismatches++;
        $display("%0t ns: mismatch on %s, got %h want %h", $realtime, what, got, want);
    endtask

    // command beat taken: work out its points
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            predict_curve_points(cur_cmd);
    end

    // point checker
    always @(posedge i_clk) begin
        t_curve_point want;
        if (i_rst_n && o_point_valid) begin
            if (curve_points_q.size() == 0) begin
                report_mismatch("point with none pending", o_point_x, C_ZERO);
            end else begin
                want = curve_points_q.pop_front();
                if (o_point_x !== want.x)
                    report_mismatch("point_x", o_point_x, want.x);
                if (o_point_y !== want.y)
                    report_mismatch("point_y", o_point_y, want.y);
                if (o_last_point !== want.last)
                    report_mismatch("last_point", COORD_W'(o_last_point), COORD_W'(want.last));
            end
        end
    end

    function automatic t_curve_cmd make_cmd(
        input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
        input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1,
        input logic [COORD_W-1:0] x2, input logic [COORD_W-1:0] y2,
        input logic [COORD_W-1:0] x3, input logic [COORD_W-1:0] y3,
        input logic [N_W-1:0] n, input logic known,
        input logic [COORD_W-1:0] kx, input logic [COORD_W-1:0] ky);
        t_curve_cmd c;
        c.pts[P0_X] = x0;
        c.pts[P0_Y] = y0;
        c.pts[P1_X] = x1;
        c.pts[P1_Y] = y1;
        c.pts[P2_X] = x2;
        c.pts[P2_Y] = y2;
        c.pts[P3_X] = x3;
        c.pts[P3_Y] = y3;
        c.steps     = n;
        c.known     = known;
        c.kx        = kx;
        c.ky        = ky;
        return c;
    endfunction

    // mostly full-range, with extremes and small values mixed in
    function automatic logic [COORD_W-1:0] rand_coord();
        int s;
        case ($urandom_range(0, 9)) inside
            0: return C_MAX;
            1: return C_MIN;
            2, 3: begin
                s = $urandom_range(0, 4000) - 2000;
                return s[COORD_W-1:0];
            end
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic t_curve_cmd rand_curve();
        t_curve_cmd c;
        for (int k = 0; k < 8; k++)
            c.pts[k] = rand_coord();
        case ($urandom_range(0, 9))
            0:       c.steps = '0;
            1:       c.steps = MAX_STEPS;
            2:       c.steps = N_W'($urandom_range(1, 4));
            default: c.steps = N_W'($urandom_range(0, 63));
        endcase
        c.known = 1'b0;
        c.kx    = '0;
        c.ky    = '0;
        return c;
    endfunction

    // present one beat and hold it until taken
    task automatic present_curve(input t_curve_cmd c);
        @(negedge i_clk);
        cur_cmd <= c;
        start   <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // start low, junk on the data lines
    task automatic idle_gap(input int cycles);
        t_curve_cmd junk;
        repeat (cycles) begin
            junk = rand_curve();
            @(negedge i_clk);
            start   <= 1'b0;
            cur_cmd <= junk;
        end
    endtask

    initial begin
        // extremes, constant curves and zero-step rows, with typed-in points where obvious
        add_row(make_cmd(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                         C_MAX, C_MAX, 6'd0, 1'b1, C_MAX, C_MAX));
        add_row(make_cmd(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                         C_MIN, C_MIN, 6'd0, 1'b1, C_MIN, C_MIN));
        add_row(make_cmd(24'h123456, 24'hABCDEF, C_MAX, C_MIN, C_MIN,
                         C_MAX, 24'h0F0F0F, 24'hF0F0F0, 6'd0, 1'b1,
                         24'h123456, 24'hABCDEF));
        add_row(make_cmd(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                         C_MAX, C_MAX, MAX_STEPS, 1'b1, C_MAX, C_MAX));
        add_row(make_cmd(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                         C_MIN, C_MIN, MAX_STEPS, 1'b1, C_MIN, C_MIN));
        add_row(make_cmd(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
                         C_MAX, C_MIN, 6'd1, 1'b1, C_MAX, C_MIN));
        add_row(make_cmd(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                         C_ZERO, C_ZERO, 6'd5, 1'b1, C_ZERO, C_ZERO));
        add_row(make_cmd(C_NEG1, C_NEG1, C_NEG1, C_NEG1, C_NEG1, C_NEG1,
                         C_NEG1, C_NEG1, 6'd4, 1'b1, C_NEG1, C_NEG1));
        // alternating extremes: sums run right up to the clamp
        add_row(make_cmd(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                         C_MAX, C_MIN, MAX_STEPS, 1'b0, '0, '0));
        add_row(make_cmd(C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX,
                         C_MIN, C_MAX, 6'd2, 1'b0, '0, '0));
        // single-LSB points: rounding half up
        add_row(make_cmd(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                         24'd1, C_NEG1, 6'd3, 1'b0, '0, '0));
        add_row(make_cmd(C_NEG1, 24'd1, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                         C_ZERO, C_ZERO, 6'd7, 1'b0, '0, '0));
        add_row(make_cmd(C_ZERO, C_ZERO, 24'd1, 24'd1, C_NEG1, C_NEG1,
                         C_ZERO, C_ZERO, 6'd9, 1'b0, '0, '0));
        // ordinary curves over assorted step counts
        add_row(make_cmd(24'h000100, 24'h000200, 24'h0A0000, 24'hF60000,
                         24'hF00000, 24'h100000, 24'h7FF000, 24'h800100,
                         6'd1, 1'b0, '0, '0));
        add_row(make_cmd(24'h000100, 24'h000200, 24'h0A0000, 24'hF60000,
                         24'hF00000, 24'h100000, 24'h7FF000, 24'h800100,
                         6'd62, 1'b0, '0, '0));
        add_row(make_cmd(24'h555555, 24'hAAAAAA, 24'h333333, 24'hCCCCCC,
                         24'h0F0F0F, 24'hF0F0F0, 24'h00FF00, 24'hFF00FF,
                         6'd32, 1'b0, '0, '0));
        add_row(make_cmd(24'hFFFF00, 24'h000100, 24'h001234, 24'hFFEDCC,
                         24'h7F0000, 24'h80FFFF, 24'h000000, 24'h000080,
                         6'd17, 1'b0, '0, '0));

        // hold reset, then release it on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats, some back to back, some spaced
        foreach (directed_rows[r]) begin
            present_curve(directed_rows[r]);
            if ($urandom_range(0, 1) == 1)
                idle_gap($urandom_range(1, 40));
        end

        // random beats; the first stretch never idles
        for (int k = 0; k < N_RANDOM; k++) begin
            present_curve(rand_curve());
            if (k >= QUIET_ITEMS && $urandom_range(0, 99) < IDLE_PCT)
                idle_gap($urandom_range(1, 100));
        end
        idle_gap(1);

        // drain, then give the block time to show any stray point
        while (curve_points_q.size() != 0)
            @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);

        if (mismatches == 0 && curve_points_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
